[sv/spt_pkg.sv]
// Package for the spin polarization transform block.
// Holds widths, status and register codes, shared types and fixed-point helpers.
// No dependencies.
package spt_pkg;

    // Default number of fraction bits of all fixed-point values.
    localparam int FRAC_BITS_DEF = 14;

    // Signed width of every intermediate value of the numerator datapath.
    localparam int VW = 48;
    // Width of a full product before rounding.
    localparam int PW = VW + 16;
    // Width of a positive divisor.
    localparam int DW = 32;
    // Width of the scaled dividend and of the division remainder.
    localparam int XW = 56;
    // Quotient bits kept by the divider; anything larger saturates.
    localparam int QB = 17;
    // Width of the sum of squares and number of square-root steps.
    localparam int SW = 32;
    localparam int SQ_N = SW / 2;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_POL_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POL_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POL_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COS_AZ = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIN_AZ = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    // Depth of the queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // Output saturation limits.
    localparam logic [QB-1:0] POS_LIMIT = 17'd32767;
    localparam logic [QB-1:0] NEG_LIMIT = 17'd32768;

    typedef struct packed {
        logic signed [15:0] pol_x;
        logic signed [15:0] pol_y;
        logic signed [15:0] pol_z;
        logic signed [15:0] cos_az;
        logic signed [15:0] sin_az;
    } cfg_t;

    // One classified item: tag, three numerators and the shared divisor.
    typedef struct packed {
        logic [15:0] tag;
        logic signed [VW-1:0] nx;
        logic signed [VW-1:0] ny;
        logic signed [VW-1:0] nz;
        logic signed [VW-1:0] den;
    } work_t;

    // Round a full product to f fraction bits, half up (floor after bias).
    function automatic logic signed [VW-1:0] rnd_q(input logic signed [PW-1:0] x,
                                                    input int f);
        logic signed [PW-1:0] bias;
        logic signed [PW-1:0] t;
        bias = PW'(1) <<< (f - 1);
        t = x + bias;
        return VW'(t >>> f);
    endfunction

    // Fixed-point product with rounding.
    function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                   input logic signed [15:0] b,
                                                   input int f);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return rnd_q(p, f);
    endfunction

endpackage

[sv/spt_if.sv]
// Channel interfaces of the spin polarization transform block.
// Uses spt_pkg for nothing; plain valid/ready channels with their payloads.
interface spt_in_if;
    logic valid;
    logic ready;
    logic [15:0] angle_tag;
    logic signed [15:0] sherman_s;
    logic signed [15:0] func_t;
    logic signed [15:0] func_u;

    modport source (output valid, angle_tag, sherman_s, func_t, func_u, input ready);
    modport sink (input valid, angle_tag, sherman_s, func_t, func_u, output ready);
endinterface

interface spt_out_if;
    logic valid;
    logic ready;
    logic [15:0] angle_out;
    logic signed [15:0] final_x;
    logic signed [15:0] final_y;
    logic signed [15:0] final_z;
    logic [14:0] final_magnitude;
    logic [1:0] status_code;

    modport source (output valid, angle_out, final_x, final_y, final_z,
                    final_magnitude, status_code, input ready);
    modport sink (input valid, angle_out, final_x, final_y, final_z,
                  final_magnitude, status_code, output ready);
endinterface

[sv/spt_regs.sv]
// Configuration registers behind an APB-style port.
// Depends on spt_pkg for the register map and the configuration struct.
module spt_regs #(
    parameter int FRAC_BITS = spt_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spt_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output spt_pkg::cfg_t               cfg
);

    spt_pkg::cfg_t cfg_reg;
    spt_pkg::cfg_t cfg_next;
    logic [spt_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx = paddr[spt_pkg::ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    // Register write decode; indexes past the map are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                spt_pkg::REG_POL_X: cfg_next.pol_x = pwdata[15:0];
                spt_pkg::REG_POL_Y: cfg_next.pol_y = pwdata[15:0];
                spt_pkg::REG_POL_Z: cfg_next.pol_z = pwdata[15:0];
                spt_pkg::REG_COS_AZ: cfg_next.cos_az = pwdata[15:0];
                spt_pkg::REG_SIN_AZ: cfg_next.sin_az = pwdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pol_x <= '0;
            cfg_reg.pol_y <= '0;
            cfg_reg.pol_z <= '0;
            cfg_reg.cos_az <= 16'(1 << FRAC_BITS);
            cfg_reg.sin_az <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (idx)
            spt_pkg::REG_POL_X: prdata = {16'b0, cfg_reg.pol_x};
            spt_pkg::REG_POL_Y: prdata = {16'b0, cfg_reg.pol_y};
            spt_pkg::REG_POL_Z: prdata = {16'b0, cfg_reg.pol_z};
            spt_pkg::REG_COS_AZ: prdata = {16'b0, cfg_reg.cos_az};
            spt_pkg::REG_SIN_AZ: prdata = {16'b0, cfg_reg.sin_az};
            default: prdata = '0;
        endcase
    end

endmodule

[sv/spt_front.sv]
// Front part: accepts input beats and forms the three numerators and the divisor.
// Depends on spt_pkg and spt_in_if; four register stages, stalls when the queue is full.
module spt_front #(
    parameter int FRAC_BITS = spt_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    spt_in_if.sink          in_ch,
    input  spt_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            q_push,
    output spt_pkg::work_t  q_data
);

    localparam int VW = spt_pkg::VW;
    localparam int PW = spt_pkg::PW;

    typedef struct packed {
        logic [15:0] tag;
        logic signed [15:0] sv;
        logic signed [15:0] tv;
        logic signed [15:0] uv;
    } s0_t;

    typedef struct packed {
        logic [15:0] tag;
        logic signed [15:0] sv;
        logic signed [15:0] tv;
        logic signed [15:0] uv;
        logic signed [VW-1:0] d;
        logic signed [VW-1:0] pzc;
        logic signed [VW-1:0] pxy;
        logic signed [VW-1:0] pzt;
        logic signed [VW-1:0] pxt;
        logic signed [VW-1:0] pyt;
        logic signed [VW-1:0] pzu;
    } s1_t;

    typedef struct packed {
        logic [15:0] tag;
        logic signed [15:0] tv;
        logic signed [VW-1:0] den;
        logic signed [VW-1:0] ds;
        logic signed [VW-1:0] dc;
        logic signed [VW-1:0] ta;
        logic signed [VW-1:0] tb;
        logic signed [VW-1:0] pzcu;
        logic signed [VW-1:0] pzus;
        logic signed [VW-1:0] xyu;
        logic signed [VW-1:0] pzt;
        logic signed [VW-1:0] pxt;
        logic signed [VW-1:0] pyt;
    } s2_t;

    logic en;
    logic s0_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg;
    s0_t s0_reg, s0_next;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    spt_pkg::work_t s3_reg, s3_next;
    logic signed [15:0] px, py, pz, c, s;
    logic signed [VW-1:0] sd;

    assign px = cfg.pol_x;
    assign py = cfg.pol_y;
    assign pz = cfg.pol_z;
    assign c = cfg.cos_az;
    assign s = cfg.sin_az;

    // The whole front moves only while the queue has room.
    assign en = !q_full;
    assign in_ch.ready = en;
    assign q_push = en && s3_vld_reg;
    assign q_data = s3_reg;

    // Stage 0: capture the input beat.
    always_comb
    begin
        s0_next.tag = in_ch.angle_tag;
        s0_next.sv = in_ch.sherman_s;
        s0_next.tv = in_ch.func_t;
        s0_next.uv = in_ch.func_u;
    end

    // Stage 1: first-level products and the azimuth term d.
    always_comb
    begin
        s1_next.tag = s0_reg.tag;
        s1_next.sv = s0_reg.sv;
        s1_next.tv = s0_reg.tv;
        s1_next.uv = s0_reg.uv;
        s1_next.d = spt_pkg::rnd_q(PW'(py) * PW'(c) - PW'(px) * PW'(s), FRAC_BITS);
        s1_next.pxy = spt_pkg::rnd_q(PW'(px) * PW'(c) + PW'(py) * PW'(s), FRAC_BITS);
        s1_next.pzc = spt_pkg::fmul(VW'(pz), c, FRAC_BITS);
        s1_next.pzt = spt_pkg::fmul(VW'(pz), s0_reg.tv, FRAC_BITS);
        s1_next.pxt = spt_pkg::fmul(VW'(px), s0_reg.tv, FRAC_BITS);
        s1_next.pyt = spt_pkg::fmul(VW'(py), s0_reg.tv, FRAC_BITS);
        s1_next.pzu = spt_pkg::fmul(VW'(pz), s0_reg.uv, FRAC_BITS);
    end

    // Stage 2: divisor and second-level products.
    always_comb
    begin
        sd = VW'(s1_reg.sv) + s1_reg.d;
        s2_next.tag = s1_reg.tag;
        s2_next.tv = s1_reg.tv;
        s2_next.den = (VW'(1) <<< FRAC_BITS) + spt_pkg::fmul(s1_reg.d, s1_reg.sv, FRAC_BITS);
        s2_next.ds = spt_pkg::fmul(s1_reg.d, s, FRAC_BITS);
        s2_next.dc = spt_pkg::fmul(s1_reg.d, c, FRAC_BITS);
        s2_next.ta = spt_pkg::fmul(-sd, s, FRAC_BITS);
        s2_next.tb = spt_pkg::fmul(sd, c, FRAC_BITS);
        s2_next.pzcu = spt_pkg::fmul(s1_reg.pzc, s1_reg.uv, FRAC_BITS);
        s2_next.pzus = spt_pkg::fmul(s1_reg.pzu, s, FRAC_BITS);
        s2_next.xyu = spt_pkg::fmul(s1_reg.pxy, s1_reg.uv, FRAC_BITS);
        s2_next.pzt = s1_reg.pzt;
        s2_next.pxt = s1_reg.pxt;
        s2_next.pyt = s1_reg.pyt;
    end

    // Stage 3: last products and the numerator sums.
    always_comb
    begin
        s3_next.tag = s2_reg.tag;
        s3_next.den = s2_reg.den;
        s3_next.nx = s2_reg.ta + s2_reg.pxt
                   + spt_pkg::fmul(s2_reg.ds, s2_reg.tv, FRAC_BITS) + s2_reg.pzcu;
        s3_next.ny = s2_reg.tb + s2_reg.pyt
                   - spt_pkg::fmul(s2_reg.dc, s2_reg.tv, FRAC_BITS) + s2_reg.pzus;
        s3_next.nz = s2_reg.pzt - s2_reg.xyu;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= in_ch.valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

endmodule

[sv/spt_queue.sv]
// Short queue between the front and back parts.
// Depends on spt_pkg for the item type and depth.
module spt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spt_pkg::work_t  push_data,
    input  logic            pop,
    output spt_pkg::work_t  head,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = spt_pkg::Q_PTR_W;
    localparam int CNT_W = PTR_W + 1;

    spt_pkg::work_t slot_reg [spt_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full = (cnt_reg == CNT_W'(spt_pkg::Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/spt_back.sv]
// Back part: pipelined division, saturation, square root and the output register.
// Depends on spt_pkg and spt_out_if; the whole pipeline moves when the output can.
module spt_back #(
    parameter int FRAC_BITS = spt_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  spt_pkg::work_t  head,
    input  logic            q_empty,
    output logic            q_pop,
    spt_out_if.source       out_ch
);

    localparam int VW = spt_pkg::VW;
    localparam int DW = spt_pkg::DW;
    localparam int XW = spt_pkg::XW;
    localparam int QB = spt_pkg::QB;
    localparam int SW = spt_pkg::SW;
    localparam int SQ_N = spt_pkg::SQ_N;

    typedef struct packed {
        logic [XW-1:0] rem;
        logic [QB-1:0] q;
        logic neg;
        logic ovf;
    } lane_t;

    typedef struct packed {
        logic [15:0] tag;
        logic fault;
        logic [DW-1:0] dv;
        lane_t [2:0] ln;
    } div_t;

    typedef struct packed {
        logic [15:0] tag;
        logic fault;
        logic sat;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
    } fin_t;

    typedef struct packed {
        fin_t f;
        logic [SW-1:0] sqx;
        logic [SW-1:0] sqy;
        logic [SW-1:0] sqz;
    } sq_t;

    typedef struct packed {
        fin_t f;
        logic [SW-1:0] v;
        logic [SW-1:0] r;
    } rt_t;

    typedef struct packed {
        logic [15:0] angle_out;
        logic signed [15:0] final_x;
        logic signed [15:0] final_y;
        logic signed [15:0] final_z;
        logic [14:0] final_magnitude;
        logic [1:0] status_code;
    } res_t;

    logic adv;
    logic div_vld_reg [QB+1];
    div_t div_reg [QB+1];
    div_t div_next [QB+1];
    logic fin_vld_reg;
    fin_t fin_reg, fin_next;
    logic sq_vld_reg;
    sq_t sq_reg, sq_next;
    logic rt_vld_reg [SQ_N+1];
    rt_t rt_reg [SQ_N+1];
    rt_t rt_next [SQ_N+1];
    logic out_vld_reg;
    res_t out_reg, out_next;

    // Scale one numerator and check for quotient overflow.
    function automatic lane_t lane_init(input logic signed [VW-1:0] n,
                                        input logic [DW-1:0] dv);
        lane_t l;
        logic [VW-1:0] mag;
        l.neg = n[VW-1];
        mag = l.neg ? VW'(-n) : VW'(n);
        l.rem = (XW'(mag) << FRAC_BITS) + XW'(dv >> 1);
        l.ovf = (l.rem >= (XW'(dv) << QB));
        l.q = '0;
        return l;
    endfunction

    // One restoring division step for quotient bit i.
    function automatic lane_t lane_step(input lane_t l, input logic [DW-1:0] dv,
                                        input int i);
        lane_t o;
        logic [XW-1:0] sh;
        o = l;
        sh = XW'(dv) << i;
        if (l.rem >= sh)
        begin
            o.rem = l.rem - sh;
            o.q = l.q | (QB'(1) << i);
        end
        return o;
    endfunction

    // Clamp a quotient to the 16-bit output range with its sign.
    function automatic logic signed [16:0] lane_clamp(input lane_t l);
        logic sat;
        logic [15:0] v;
        sat = 1'b0;
        if (l.neg)
        begin
            if (l.ovf || l.q > spt_pkg::NEG_LIMIT)
            begin
                sat = 1'b1;
                v = 16'h8000;
            end
            else
            begin
                v = 16'(-l.q);
            end
        end
        else
        begin
            if (l.ovf || l.q > spt_pkg::POS_LIMIT)
            begin
                sat = 1'b1;
                v = 16'h7fff;
            end
            else
            begin
                v = l.q[15:0];
            end
        end
        return {sat, v};
    endfunction

    assign adv = !out_vld_reg || out_ch.ready;
    assign q_pop = adv && !q_empty;

    // Entry stage: fault check and dividend scaling.
    always_comb
    begin
        div_next[0].tag = head.tag;
        div_next[0].fault = head.den[VW-1] || (head.den == '0);
        div_next[0].dv = head.den[DW-1:0];
        div_next[0].ln[0] = lane_init(head.nx, head.den[DW-1:0]);
        div_next[0].ln[1] = lane_init(head.ny, head.den[DW-1:0]);
        div_next[0].ln[2] = lane_init(head.nz, head.den[DW-1:0]);
    end

    // Division stages, one quotient bit each, most significant first.
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        always_comb
        begin
            div_next[k+1] = div_reg[k];
            for (int j = 0; j < 3; j++)
            begin
                div_next[k+1].ln[j] = lane_step(div_reg[k].ln[j], div_reg[k].dv, QB - 1 - k);
            end
        end
    end

    // Saturation stage.
    always_comb
    begin
        logic signed [16:0] cx, cy, cz;
        cx = lane_clamp(div_reg[QB].ln[0]);
        cy = lane_clamp(div_reg[QB].ln[1]);
        cz = lane_clamp(div_reg[QB].ln[2]);
        fin_next.tag = div_reg[QB].tag;
        fin_next.fault = div_reg[QB].fault;
        if (div_reg[QB].fault)
        begin
            fin_next.sat = 1'b0;
            fin_next.fx = '0;
            fin_next.fy = '0;
            fin_next.fz = '0;
        end
        else
        begin
            fin_next.sat = cx[16] || cy[16] || cz[16];
            fin_next.fx = cx[15:0];
            fin_next.fy = cy[15:0];
            fin_next.fz = cz[15:0];
        end
    end

    // Squares of the clamped components.
    always_comb
    begin
        sq_next.f = fin_reg;
        sq_next.sqx = SW'(fin_reg.fx * fin_reg.fx);
        sq_next.sqy = SW'(fin_reg.fy * fin_reg.fy);
        sq_next.sqz = SW'(fin_reg.fz * fin_reg.fz);
    end

    // Square-root entry: sum of squares.
    always_comb
    begin
        rt_next[0].f = sq_reg.f;
        rt_next[0].v = sq_reg.sqx + sq_reg.sqy + sq_reg.sqz;
        rt_next[0].r = '0;
    end

    // Square-root stages, one result bit each.
    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sqrt
        always_comb
        begin
            logic [SW-1:0] bitv;
            logic [SW:0] trial;
            bitv = SW'(1) << (2 * (SQ_N - 1 - j));
            trial = {1'b0, rt_reg[j].r} + {1'b0, bitv};
            rt_next[j+1] = rt_reg[j];
            if ({1'b0, rt_reg[j].v} >= trial)
            begin
                rt_next[j+1].v = rt_reg[j].v - trial[SW-1:0];
                rt_next[j+1].r = (rt_reg[j].r >> 1) + bitv;
            end
            else
            begin
                rt_next[j+1].r = rt_reg[j].r >> 1;
            end
        end
    end

    // Final rounding of the magnitude, clamp and status.
    always_comb
    begin
        logic [SW-1:0] m;
        logic msat;
        m = rt_reg[SQ_N].r + SW'(rt_reg[SQ_N].v > rt_reg[SQ_N].r);
        msat = (m > SW'(spt_pkg::POS_LIMIT));
        out_next.angle_out = rt_reg[SQ_N].f.tag;
        out_next.final_x = rt_reg[SQ_N].f.fx;
        out_next.final_y = rt_reg[SQ_N].f.fy;
        out_next.final_z = rt_reg[SQ_N].f.fz;
        if (rt_reg[SQ_N].f.fault)
        begin
            out_next.final_magnitude = '0;
            out_next.status_code = spt_pkg::ST_FAULT;
        end
        else
        begin
            out_next.final_magnitude = msat ? 15'h7fff : m[14:0];
            out_next.status_code = (msat || rt_reg[SQ_N].f.sat) ? spt_pkg::ST_SAT
                                                                 : spt_pkg::ST_OK;
        end
    end

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                div_vld_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= SQ_N; j++)
            begin
                rt_vld_reg[j] <= 1'b0;
            end
            fin_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            div_vld_reg[0] <= !q_empty;
            for (int k = 0; k < QB; k++)
            begin
                div_vld_reg[k+1] <= div_vld_reg[k];
            end
            fin_vld_reg <= div_vld_reg[QB];
            sq_vld_reg <= fin_vld_reg;
            rt_vld_reg[0] <= sq_vld_reg;
            for (int j = 0; j < SQ_N; j++)
            begin
                rt_vld_reg[j+1] <= rt_vld_reg[j];
            end
            out_vld_reg <= rt_vld_reg[SQ_N];
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            fin_reg <= fin_next;
            sq_reg <= sq_next;
            for (int j = 0; j <= SQ_N; j++)
            begin
                rt_reg[j] <= rt_next[j];
            end
            if (rt_vld_reg[SQ_N])
            begin
                out_reg <= out_next;
            end
        end
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.angle_out = out_reg.angle_out;
    assign out_ch.final_x = out_reg.final_x;
    assign out_ch.final_y = out_reg.final_y;
    assign out_ch.final_z = out_reg.final_z;
    assign out_ch.final_magnitude = out_reg.final_magnitude;
    assign out_ch.status_code = out_reg.status_code;

endmodule

[sv/spin_polarization_transform_top.sv]
// Top level of the spin polarization transform block.
// Depends on spt_pkg, spt_if, spt_regs, spt_front, spt_queue and spt_back.
//
// Usage: write pol_x, pol_y, pol_z, cos_azimuth and sin_azimuth (Q1.14, one
// per 32-bit word at byte addresses 0, 4, 8, 12, 16) while the block is idle.
// Each beat on in_ch carries an angle tag and S, T, U; each beat on out_ch
// carries the tag, the final polarization components, their magnitude and a
// status code (ok, saturated, or non-positive divisor with zero outputs).
// Throughput is one beat per cycle unless out_ch stalls. On its way to out_ch
// a beat passes 3 front stages after the capture register, one queue slot
// and 38 back stages (entry, 17 division steps, one per quotient bit, then
// clamp, squares, square-root entry, 16 square-root steps and the output
// register).
// When out_ch stalls the back pipeline holds; the four-entry queue fills,
// then the front holds and in_ch.ready falls.
// Reset clears all valid bits, empties the queue and loads the configuration
// defaults (cosine 1.0, all others 0); no clearing pass is needed.
module spin_polarization_transform_top #(
    parameter int FRAC_BITS = spt_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spt_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    spt_in_if.sink                      in_ch,
    spt_out_if.source                   out_ch
);

    spt_pkg::cfg_t cfg;
    spt_pkg::work_t q_in, q_head;
    logic q_push, q_pop, q_full, q_empty;

    spt_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    spt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg),
        .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    spt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .pop(q_pop),
        .head(q_head), .full(q_full), .empty(q_empty)
    );

    spt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .head(q_head), .q_empty(q_empty),
        .q_pop(q_pop), .out_ch(out_ch)
    );

`ifndef SYNTHESIS
    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // A divisor fault beat carries zero components and magnitude.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status_code == spt_pkg::ST_FAULT) |->
        (out_ch.final_x == '0 && out_ch.final_y == '0 && out_ch.final_z == '0
         && out_ch.final_magnitude == '0))
        else $error("fault beat with nonzero result");
`endif

endmodule

[dv/tb_top.sv]
// Testbench for the spin polarization transform block: directed and random beats.
// Predicts each result in SystemVerilog and checks it; depends on spt_pkg, spt_if
// and the RTL of spin_polarization_transform_top.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [15:0] angle;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic [14:0] mag;
        logic [1:0] status;
    } polar_t;

    localparam int F = 14;
    localparam int ONE = 1 << F;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [spt_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    spt_in_if in_ch ();
    spt_out_if out_ch ();

    spin_polarization_transform_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // Local copy of the configuration registers.
    logic signed [15:0] m_px, m_py, m_pz, m_cos, m_sin;

    polar_t pending_results[$];
    int mismatches;
    int checked;
    int faults_seen, sats_seen;
    bit quiet_out;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #20ms;
        $display("** spin_polarization_transform_top: FAILED **");
        $finish;
    end

    // Round half up to F fraction bits.
    function automatic longint round_q(input longint x);
        longint t;
        t = x + (64'sd1 <<< (F - 1));
        return t >>> F;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return round_q(a * b);
    endfunction

    // Quotient N*2^F/D, nearest with ties away from zero, then clamped.
    function automatic longint qdiv(input longint n, input longint d, inout bit sat);
        longint mag;
        longint q;
        mag = (n < 0 ? -n : n) <<< F;
        q = (mag + d / 2) / d;
        if (n >= 0 && q > 32767)
        begin
            sat = 1;
            return 32767;
        end
        if (n < 0 && q > 32768)
        begin
            sat = 1;
            return -32768;
        end
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint root_nearest(input longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r = r + 1;
        if (v - r * r > r)
            r = r + 1;
        return r;
    endfunction

    // Final polarization for one set of scattering functions.
    function automatic polar_t transfer_polarization(input logic [15:0] tag,
            input logic signed [15:0] sv, input logic signed [15:0] tv,
            input logic signed [15:0] uv);
        polar_t r;
        longint px, py, pz, c, s, d, den, nx, ny, nz, fx, fy, fz, sq, mg;
        bit sat;
        px = m_px;
        py = m_py;
        pz = m_pz;
        c = m_cos;
        s = m_sin;
        sat = 0;
        r = '0;
        r.angle = tag;
        d = round_q(py * c - px * s);
        den = ONE + qmul(sv, d);
        if (den <= 0)
        begin
            r.status = spt_pkg::ST_FAULT;
            return r;
        end
        nx = qmul(-(sv + d), s) + qmul(px, tv) + qmul(qmul(d, s), tv)
            + qmul(qmul(pz, c), uv);
        ny = qmul(sv + d, c) + qmul(py, tv) - qmul(qmul(d, c), tv)
            + qmul(qmul(pz, uv), s);
        nz = qmul(pz, tv) - qmul(round_q(px * c + py * s), uv);
        fx = qdiv(nx, den, sat);
        fy = qdiv(ny, den, sat);
        fz = qdiv(nz, den, sat);
        sq = fx * fx + fy * fy + fz * fz;
        mg = root_nearest(sq);
        if (mg > 32767)
        begin
            mg = 32767;
            sat = 1;
        end
        r.fx = fx[15:0];
        r.fy = fy[15:0];
        r.fz = fz[15:0];
        r.mag = mg[14:0];
        r.status = sat ? spt_pkg::ST_SAT : spt_pkg::ST_OK;
        return r;
    endfunction

    // Receiver: random stalls, then compare each beat with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        polar_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.angle_out, out_ch.final_x, out_ch.final_y, out_ch.final_z,
                    out_ch.final_magnitude, out_ch.status_code};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (got.status == spt_pkg::ST_FAULT)
                    faults_seen++;
                if (got.status == spt_pkg::ST_SAT)
                    sats_seen++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch tag %0d: expected %p, got %p",
                                 want.angle, want, got);
                end
            end
        end
    end

    task automatic write_reg(input logic [spt_pkg::REG_IDX_W-1:0] idx,
            input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= spt_pkg::ADDR_W'(idx) << 2;
        pwdata <= {{16{value[15]}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            spt_pkg::REG_POL_X: m_px = value;
            spt_pkg::REG_POL_Y: m_py = value;
            spt_pkg::REG_POL_Z: m_pz = value;
            spt_pkg::REG_COS_AZ: m_cos = value;
            default: m_sin = value;
        endcase
    endtask

    task automatic load_config(input logic [15:0] px, input logic [15:0] py,
            input logic [15:0] pz, input logic [15:0] c, input logic [15:0] s);
        write_reg(spt_pkg::REG_POL_X, px);
        write_reg(spt_pkg::REG_POL_Y, py);
        write_reg(spt_pkg::REG_POL_Z, pz);
        write_reg(spt_pkg::REG_COS_AZ, c);
        write_reg(spt_pkg::REG_SIN_AZ, s);
    endtask

    // Sends one beat; the sender idles now and then unless told not to.
    task automatic send_beat(input logic [15:0] tag, input logic [15:0] sv,
            input logic [15:0] tv, input logic [15:0] uv, input bit steady);
        if (!steady)
        begin
            while ($urandom_range(99) < 9)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.angle_tag <= tag;
        in_ch.sherman_s <= sv;
        in_ch.func_t <= tv;
        in_ch.func_u <= uv;
        pending_results.push_back(transfer_polarization(tag, sv, tv, uv));
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_q1();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'h8000;
            2: return 16'sd16384;
            3: return -16'sd16384;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    // Field extremes, the fault divisor and saturating cases at reset config too.
    task automatic test_directed();
        send_beat(16'h0000, 16'sd0, 16'sd0, 16'sd0, 1);
        send_beat(16'hFFFF, 16'sd16384, 16'sd16384, 16'sd16384, 1);
        stop_sending();
        drain();
        load_config(16'sd16384, 16'sd16384, 16'sd16384, 16'sd0, 16'sd16384);
        send_beat(16'h1234, 16'sd16384, 16'sd0, 16'sd0, 1);   // divisor exactly zero
        send_beat(16'h4321, 16'h8000, 16'h8000, 16'h8000, 1);
        send_beat(16'h5555, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
        send_beat(16'hAAAA, -16'sd16384, 16'sd16384, -16'sd16384, 1);
        send_beat(16'h00FF, 16'sd8000, -16'sd16384, 16'sd16384, 1);
        send_beat(16'hFF00, -16'sd12000, 16'h7FFF, 16'h8000, 0);
        stop_sending();
        drain();
        load_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_beat(16'h0001, 16'sd1, 16'sd1, 16'sd1, 1);
        send_beat(16'h0002, 16'h7FFF, 16'h8000, 16'h7FFF, 1);
        send_beat(16'h0003, -16'sd1, -16'sd1, -16'sd1, 1);
        send_beat(16'h0004, 16'h8000, 16'sd100, -16'sd100, 1);
        stop_sending();
        drain();
    endtask

    // Random beats over several random configurations, both sides idling.
    task automatic test_random(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            load_config(rand_q1(), rand_q1(), rand_q1(), rand_q1(), rand_q1());
            for (int i = 0; i < per_phase; i++)
                send_beat(16'($urandom), rand_q1(), rand_q1(), rand_q1(), 0);
            stop_sending();
            drain();
        end
    endtask

    // A long stretch with no idling on either side at physical polarizations.
    task automatic test_full_rate();
        quiet_out = 1;
        load_config(16'sd6000, -16'sd9000, 16'sd11000, 16'sd11585, 16'sd11585);
        for (int i = 0; i < 200; i++)
            send_beat(16'($urandom), 16'($urandom_range(16384) - 8192),
                      16'($urandom_range(32768) - 16384),
                      16'($urandom_range(32768) - 16384), 1);
        stop_sending();
        drain();
        quiet_out = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        quiet_out = 0;
        mismatches = 0;
        checked = 0;
        faults_seen = 0;
        sats_seen = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.angle_tag = '0;
        in_ch.sherman_s = '0;
        in_ch.func_t = '0;
        in_ch.func_u = '0;
        m_px = 0;
        m_py = 0;
        m_pz = 0;
        m_cos = 16'sd16384;
        m_sin = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_rate();
        test_random(11, 100);

        $display("Checked %0d result beats: %0d saturated, %0d with a non-positive divisor.",
                 checked, sats_seen, faults_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** spin_polarization_transform_top: PASSED **");
        else
            $display("** spin_polarization_transform_top: FAILED **");
        $finish;
    end
endmodule

[sim.f]
sv/spt_pkg.sv
sv/spt_if.sv
sv/spt_regs.sv
sv/spt_front.sv
sv/spt_queue.sv
sv/spt_back.sv
sv/spin_polarization_transform_top.sv
dv/tb_top.sv
